FILE: hw/rtl/mfbp_pkg.sv
// shared types and constants for the msb-first bit packer
// no dependencies; imported by every module of the block
package mfbp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int FIELD_W   = 32;
  localparam int LEN_W     = 6;
  // byte count of one job; covers accumulators up to 120 bits
  localparam int CNT_W     = 4;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [CNT_W-1:0]   nbytes;
  } job_ctl_t;

endpackage

FILE: hw/rtl/mfbp_front.sv
// front end: accepts items, keeps the partial byte, builds byte and status jobs
// depends on mfbp_pkg; feeds mfbp_queue
module mfbp_front import mfbp_pkg::*; #(
  parameter int ACC_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                action,
  input  logic [FIELD_W-1:0]  field_value,
  input  logic [LEN_W-1:0]    field_length,
  input  logic                q_full,
  output logic                wr_en,
  output job_ctl_t            wr_ctl,
  output logic [ACC_BITS-1:0] wr_data
);

  localparam int VW    = (ACC_BITS > FIELD_W) ? ACC_BITS : FIELD_W;
  localparam int TOT_W = LEN_W + 1;
  localparam int SH_W  = $clog2(ACC_BITS + 1);
  localparam int PB    = BYTE_BITS - 1;

  // partial byte: fewer than a byte's worth of bits is ever held
  logic [PB-1:0]       acc;
  logic [2:0]          held;

  logic                accept;
  logic [TOT_W-1:0]    total;
  logic                reject;
  logic [VW-1:0]       vmask;
  logic [VW-1:0]       vmasked;
  logic [ACC_BITS-1:0] vnarrow;
  logic [SH_W-1:0]     sh_acc;
  logic [SH_W-1:0]     sh_new;
  logic [ACC_BITS-1:0] acc_aligned;
  logic [ACC_BITS-1:0] push_aligned;
  logic [2:0]          rem;
  logic [PB-1:0]       rem_mask;
  logic [PB-1:0]       acc_tail;
  logic [CNT_W-1:0]    push_bytes;

  assign item_stall = q_full;
  assign accept     = item_valid & ~q_full;

  assign total   = TOT_W'(held) + TOT_W'(field_length);
  assign reject  = (total > TOT_W'(ACC_BITS));
  assign vmask   = ~({VW{1'b1}} << field_length);
  assign vmasked = VW'(field_value) & vmask;
  assign vnarrow = vmasked[ACC_BITS-1:0];

  assign sh_acc = SH_W'(TOT_W'(ACC_BITS) - TOT_W'(held));
  assign sh_new = SH_W'(TOT_W'(ACC_BITS) - total);

  // held bits on top, new field right below them, rest zero
  assign acc_aligned  = ACC_BITS'(acc) << sh_acc;
  assign push_aligned = acc_aligned | (vnarrow << sh_new);

  assign rem        = total[2:0];
  assign rem_mask   = ~({PB{1'b1}} << rem);
  assign acc_tail   = ((acc << field_length) | vmasked[PB-1:0]) & rem_mask;
  assign push_bytes = CNT_W'(total >> 3);

  always_comb begin
    wr_en          = 1'b0;
    wr_ctl.status  = ST_BYTE;
    wr_ctl.nbytes  = CNT_W'(1);
    wr_data        = '0;
    if (action == ACT_PUSH) begin
      if (reject) begin
        wr_en         = accept;
        wr_ctl.status = ST_OVERFLOW;
      end else begin
        wr_en         = accept & (push_bytes != '0);
        wr_ctl.nbytes = push_bytes;
        wr_data       = push_aligned;
      end
    end else begin
      wr_en = accept;
      if (held == 3'd0) begin
        wr_ctl.status = ST_EMPTY;
      end else begin
        wr_data = acc_aligned;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
    end else if (accept) begin
      if (action == ACT_FLUSH) begin
        acc  <= '0;
        held <= '0;
      end else if (!reject) begin
        acc  <= acc_tail;
        held <= rem;
      end
    end
  end

endmodule

FILE: hw/rtl/mfbp_queue.sv
// two-entry job queue between the front end and the byte emitter
// depends on mfbp_pkg
module mfbp_queue import mfbp_pkg::*; #(
  parameter int ACC_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  job_ctl_t            wr_ctl,
  input  logic [ACC_BITS-1:0] wr_data,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output job_ctl_t            rd_ctl,
  output logic [ACC_BITS-1:0] rd_data
);

  logic [1:0]          count;
  job_ctl_t            ctl0, ctl1;
  logic [ACC_BITS-1:0] data0, data1;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_ctl   = ctl0;
  assign rd_data  = data0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  // head always sits in slot 0
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && count == 2'd1) begin
        ctl0  <= wr_ctl;
        data0 <= wr_data;
      end else begin
        ctl0  <= ctl1;
        data0 <= data1;
      end
      if (wr_en && count == 2'd2) begin
        ctl1  <= wr_ctl;
        data1 <= wr_data;
      end
    end else if (wr_en) begin
      if (count == 2'd0) begin
        ctl0  <= wr_ctl;
        data0 <= wr_data;
      end else begin
        ctl1  <= wr_ctl;
        data1 <= wr_data;
      end
    end
  end

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr_en)
    else $error("job queue written while full");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_valid)
    else $error("job queue popped while empty");

endmodule

FILE: hw/rtl/mfbp_back.sv
// back end: unpacks jobs to bytes, one per unstalled cycle, to an output register
// depends on mfbp_pkg; pops mfbp_queue
module mfbp_back import mfbp_pkg::*; #(
  parameter int ACC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  job_ctl_t             q_ctl,
  input  logic [ACC_BITS-1:0]  q_data,
  output logic                 q_pop,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 last,
  output logic [1:0]           status
);

  logic                 advance;
  logic [CNT_W-1:0]     cur_cnt;
  logic [ACC_BITS-1:0]  cur_data;
  status_t              cur_status;
  logic                 o_valid;
  logic [BYTE_BITS-1:0] o_byte;
  logic                 o_last;
  status_t              o_status;

  assign advance    = ~o_valid | ~byte_stall;
  assign q_pop      = advance & (cur_cnt == '0) & q_valid;
  assign byte_valid = o_valid;
  assign out_byte   = o_byte;
  assign last       = o_last;
  assign status     = o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      cur_cnt <= '0;
    end else if (advance) begin
      if (cur_cnt != '0) begin
        o_valid <= 1'b1;
        cur_cnt <= cur_cnt - CNT_W'(1);
      end else if (q_valid) begin
        o_valid <= 1'b1;
        cur_cnt <= q_ctl.nbytes - CNT_W'(1);
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  // oldest bits sit at the top of the job word
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cur_cnt != '0) begin
        o_byte   <= cur_data[ACC_BITS-1 -: BYTE_BITS];
        o_last   <= (cur_cnt == CNT_W'(1));
        o_status <= cur_status;
        cur_data <= cur_data << BYTE_BITS;
      end else if (q_valid) begin
        o_byte     <= q_data[ACC_BITS-1 -: BYTE_BITS];
        o_last     <= (q_ctl.nbytes == CNT_W'(1));
        o_status   <= q_ctl.status;
        cur_data   <= q_data << BYTE_BITS;
        cur_status <= q_ctl.status;
      end
    end
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_status != ST_BYTE) |-> o_last)
    else $error("error status not marked last");

  a_pending_has_output: assert property (@(posedge clk) disable iff (rst)
    (cur_cnt != '0) |-> o_valid)
    else $error("bytes pending with empty output register");

  a_no_pop_midjob: assert property (@(posedge clk) disable iff (rst)
    (cur_cnt != '0) |-> !q_pop)
    else $error("job popped while previous job still emitting");

endmodule

FILE: hw/rtl/msb_first_bit_packer_unit.sv
// msb-first bit packer, top level: front end, job queue, byte emitter
// depends on mfbp_pkg, mfbp_front, mfbp_queue, mfbp_back
//
// Packs fields of 0 to 32 bits, most significant bit first, into bytes.
// An item is taken in every cycle while the two-entry job queue has room;
// it is turned into at most one job in the same cycle, and the held partial
// byte is updated at once. The emitter sends one byte per cycle through an
// output register while byte_stall is low, so the sustained rate is one
// result per cycle, set by that port. A result passes through the job queue
// and then the output register. An overflowing push or a flush with nothing
// held gives one result with status 1 or 2; a push that completes no byte
// gives none.
module msb_first_bit_packer_unit import mfbp_pkg::*; #(
  parameter int ACC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 action,
  input  logic [FIELD_W-1:0]   field_value,
  input  logic [LEN_W-1:0]     field_length,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 last,
  output logic [1:0]           status
);

  logic                wr_en;
  job_ctl_t            wr_ctl;
  logic [ACC_BITS-1:0] wr_data;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  job_ctl_t            q_ctl;
  logic [ACC_BITS-1:0] q_data;

  mfbp_front #(.ACC_BITS(ACC_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .field_value  (field_value),
    .field_length (field_length),
    .q_full       (q_full),
    .wr_en        (wr_en),
    .wr_ctl       (wr_ctl),
    .wr_data      (wr_data)
  );

  mfbp_queue #(.ACC_BITS(ACC_BITS)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_ctl   (wr_ctl),
    .wr_data  (wr_data),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_ctl   (q_ctl),
    .rd_data  (q_data)
  );

  mfbp_back #(.ACC_BITS(ACC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last       (last),
    .status     (status)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for msb_first_bit_packer_unit: directed and random
// field pushes and flushes, predicted byte stream checked on the byte port
// depends on mfbp_pkg and the packer rtl
module tb_top;
  import mfbp_pkg::*;

  localparam int PACK_BITS = 32;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
    status_t              status;
  } byte_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 action = ACT_PUSH;
  logic [FIELD_W-1:0]   field_value = '0;
  logic [LEN_W-1:0]     field_length = '0;
  logic                 byte_valid;
  logic                 byte_stall = 1'b0;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 last;
  logic [1:0]           status;

  // predicted packer state
  logic [63:0] acc_bits = '0;
  int          acc_count = 0;

  byte_rec_t pending_bytes[$];
  int        errors = 0;
  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;
  int        stall_left = 0;

  msb_first_bit_packer_unit #(.ACC_BITS(PACK_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .field_value  (field_value),
    .field_length (field_length),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .out_byte     (out_byte),
    .last         (last),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] low_bits(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void emit_byte(input logic [7:0] b, input logic lst, input status_t st);
    byte_rec_t r;
    r.data   = b;
    r.last   = lst;
    r.status = st;
    pending_bytes.push_back(r);
  endfunction

  // expected bytes of one accepted transaction
  function automatic void predict_bytes(input logic act, input logic [31:0] val,
                                        input logic [5:0] len);
    int nfull;
    bit partial;
    if (act == ACT_PUSH) begin
      if (acc_count + int'(len) > PACK_BITS) begin
        emit_byte(8'h00, 1'b1, ST_OVERFLOW);
        return;
      end
      acc_bits  = (acc_bits << len) | ({32'd0, val} & low_bits(len));
      acc_count = acc_count + int'(len);
      acc_bits  = acc_bits & low_bits(acc_count);
      partial   = 1'b0;
    end else begin
      if (acc_count == 0) begin
        emit_byte(8'h00, 1'b1, ST_EMPTY);
        return;
      end
      partial = (acc_count % BYTE_BITS) != 0;
    end
    nfull = acc_count / BYTE_BITS;
    for (int i = 0; i < nfull; i++) begin
      acc_count = acc_count - BYTE_BITS;
      emit_byte(8'(acc_bits >> acc_count), (i == nfull - 1) && !partial, ST_BYTE);
      acc_bits = acc_bits & low_bits(acc_count);
    end
    if (partial) emit_byte(8'(acc_bits << (BYTE_BITS - acc_count)), 1'b1, ST_BYTE);
    if (act == ACT_FLUSH) begin
      acc_bits  = '0;
      acc_count = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly fields that fit the free room, short ones favored; some noise
  function automatic logic [5:0] pick_len();
    int r;
    int room;
    int len;
    r    = $urandom_range(0, 99);
    room = PACK_BITS - acc_count;
    if (r < 12) return 6'($urandom_range(0, 63));
    if (r < 60) len = $urandom_range(0, 8);
    else if (r < 82) len = $urandom_range(9, 16);
    else len = $urandom_range(17, 32);
    if (len > room) len = $urandom_range(0, room);
    return 6'(len);
  endfunction

  // valid stays high between back-to-back transactions
  task automatic send_item(input logic act, input logic [31:0] val, input logic [5:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    action       <= act;
    field_value  <= val;
    field_length <= len;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_bytes(act, val, len);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    if ($urandom_range(0, 99) < 10) send_item(ACT_FLUSH, $urandom, 6'($urandom_range(0, 63)));
    else send_item(ACT_PUSH, $urandom, pick_len());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      byte_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      byte_stall <= 1'b1;
    end else begin
      byte_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_bytes
    byte_rec_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected transaction: out_byte %h last %b status %0d", out_byte, last, status);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h actual %h", want.data, out_byte);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %b actual %b", want.last, last);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_push();
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 6'd0);
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 6'd32);
    send_item(ACT_PUSH, 32'h1234_5678, 6'd33);
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 6'd63);
    // high bits above the length must be dropped
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 6'd3);
    send_item(ACT_PUSH, 32'hDEAD_BEEF, 6'd30);
    // exactly fills the accumulator
    send_item(ACT_PUSH, 32'h0ABC_DEF1, 6'd29);
    send_item(ACT_PUSH, 32'h0000_00A5, 6'd8);
    send_item(ACT_PUSH, 32'h0000_0ABC, 6'd12);
    send_item(ACT_PUSH, 32'h0FED_CBA9, 6'd28);
    send_item(ACT_PUSH, 32'h0000_0000, 6'd32);
  endtask

  task automatic test_directed_flush();
    send_item(ACT_FLUSH, 32'h0, 6'd0);
    send_item(ACT_PUSH, 32'hFFFF_FFFF, 6'd0);
    send_item(ACT_FLUSH, 32'hFFFF_FFFF, 6'd63);
    for (int i = 0; i < 7; i++) send_item(ACT_PUSH, 32'(i & 1), 6'd1);
    send_item(ACT_FLUSH, 32'h0, 6'd0);
    send_item(ACT_PUSH, 32'h0000_001F, 6'd5);
    send_item(ACT_FLUSH, 32'h0, 6'd0);
    send_item(ACT_PUSH, 32'h0000_0000, 6'd4);
    send_item(ACT_FLUSH, 32'h0, 6'd0);
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < 125; i++) send_random();
  endtask

  // sender holds off until the byte port has drained, then resumes
  task automatic test_drain_pause();
    for (int i = 0; i < 10; i++) send_random();
    wait_drained();
    for (int i = 0; i < 10; i++) send_random();
  endtask

  task automatic test_no_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 40; i++) send_random();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_push();
    test_directed_flush();
    test_random_stream();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected transactions never arrived", pending_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mfbp_pkg.sv
hw/rtl/mfbp_front.sv
hw/rtl/mfbp_queue.sv
hw/rtl/mfbp_back.sv
hw/rtl/msb_first_bit_packer_unit.sv
tb/tb_top.sv
